>>> rtl/core/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue.
package spq_pkg;

  localparam int DEPTH_DEF         = 8;
  localparam int VALUE_BITS_DEF    = 16;
  localparam int PRIORITY_BITS_DEF = 8;

  localparam int COUNT_FIELD_BITS  = 4;
  localparam int STATUS_BITS       = 2;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  // Per-cycle operation broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

>>> rtl/core/spq_cell.sv
// One slot of the sorted queue: holds a value and a priority and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell #(
  parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                     clk,
  input  spq_pkg::cell_ctl_t       ctl,
  input  logic                     occupied,
  input  logic [VALUE_BITS-1:0]    new_val,
  input  logic [PRIORITY_BITS-1:0] new_pri,
  input  logic                     left_ge,
  input  logic [VALUE_BITS-1:0]    left_val,
  input  logic [PRIORITY_BITS-1:0] left_pri,
  input  logic [VALUE_BITS-1:0]    right_val,
  input  logic [PRIORITY_BITS-1:0] right_pri,
  output logic                     ge,
  output logic [VALUE_BITS-1:0]    val,
  output logic [PRIORITY_BITS-1:0] pri
);

  logic [VALUE_BITS-1:0]    val_r, val_nxt;
  logic [PRIORITY_BITS-1:0] pri_r, pri_nxt;

  // Held entry stays ahead of the new one on equal priority
  assign ge = occupied && (pri_r >= new_pri);

  always_comb begin
    val_nxt = val_r;
    pri_nxt = pri_r;
    if (ctl.ins && !ge) begin
      if (left_ge) begin
        val_nxt = new_val;
        pri_nxt = new_pri;
      end else begin
        val_nxt = left_val;
        pri_nxt = left_pri;
      end
    end else if (ctl.rem) begin
      val_nxt = right_val;
      pri_nxt = right_pri;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    pri_r <= pri_nxt;
  end

  assign val = val_r;
  assign pri = pri_r;

endmodule

>>> rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of spq_cell slots plus count and result register.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   Input stream: in_tuser selects the command (0 insert, 1 remove the head);
//   in_tdata carries the value and priority of an insert.
//   Result stream: one transfer per input transfer. out_tuser gives the status
//   (0 done, 1 overflow, 2 underflow); out_tdata gives the removed value and
//   priority (zero unless a remove succeeded) and the entry count afterward.
//   Each command is applied to the whole cell chain in the cycle it is taken,
//   and its result is registered in the result register; one command per cycle is
//   sustained while the result side keeps up. The chain shifts one slot per
//   cell in that same cycle, so the rate is set by the compare in each cell.
//   If the receiver stalls, the held result stays put and in_tready is low
//   until it is taken (in_tready = !out_tvalid || out_tready).
//   Reset empties the queue (count zero) and drops any pending result; slot
//   contents are not cleared, since only slots below the count are read.
module sorted_priority_queue #(
  parameter int DEPTH         = spq_pkg::DEPTH_DEF,
  parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  localparam int IN_W  = ((VALUE_BITS + PRIORITY_BITS + 7) / 8) * 8,
  localparam int OUT_W =
    ((VALUE_BITS + PRIORITY_BITS + spq_pkg::COUNT_FIELD_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_W-1:0]                 in_tdata,   // item_value, item_priority, zero pad
  input  logic                            in_tuser,   // command
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_W-1:0]                out_tdata,  // out_value, out_priority, entry_count, pad
  output logic [spq_pkg::STATUS_BITS-1:0] out_tuser   // status
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PB = VALUE_BITS + PRIORITY_BITS;
  localparam int CB = spq_pkg::COUNT_FIELD_BITS;

  logic [CW-1:0]              count_r, count_nxt;
  logic                       out_valid_r;
  logic [OUT_W-1:0]           out_data_r, out_data_nxt;
  spq_pkg::status_t           status_r, status_nxt;

  logic                       accept, full, empty;
  spq_pkg::cell_ctl_t         ctl;
  logic [VALUE_BITS-1:0]      new_val;
  logic [PRIORITY_BITS-1:0]   new_pri;

  logic [DEPTH-1:0]           ge;
  logic [VALUE_BITS-1:0]      val    [DEPTH];
  logic [PRIORITY_BITS-1:0]   pri    [DEPTH];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign new_val   = in_tdata[VALUE_BITS-1:0];
  assign new_pri   = in_tdata[PB-1:VALUE_BITS];

  assign ctl.ins = accept && (in_tuser == spq_pkg::CMD_INSERT) && !full;
  assign ctl.rem = accept && (in_tuser == spq_pkg::CMD_REMOVE) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     l_ge;
    logic [VALUE_BITS-1:0]    l_val, r_val;
    logic [PRIORITY_BITS-1:0] l_pri, r_pri;

    if (i == 0) begin : g_head
      assign l_ge  = 1'b1;
      assign l_val = val[i];
      assign l_pri = pri[i];
    end else begin : g_mid
      assign l_ge  = ge[i-1];
      assign l_val = val[i-1];
      assign l_pri = pri[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_val = val[i];
      assign r_pri = pri[i];
    end else begin : g_body
      assign r_val = val[i+1];
      assign r_pri = pri[i+1];
    end

    spq_cell #(
      .VALUE_BITS    (VALUE_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (CW'(i) < count_r),
      .new_val   (new_val),
      .new_pri   (new_pri),
      .left_ge   (l_ge),
      .left_val  (l_val),
      .left_pri  (l_pri),
      .right_val (r_val),
      .right_pri (r_pri),
      .ge        (ge[i]),
      .val       (val[i]),
      .pri       (pri[i])
    );
  end

  always_comb begin
    count_nxt    = count_r;
    status_nxt   = spq_pkg::STATUS_DONE;
    out_data_nxt = '0;
    if (in_tuser == spq_pkg::CMD_INSERT) begin
      if (full) begin
        status_nxt = spq_pkg::STATUS_OVERFLOW;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = spq_pkg::STATUS_UNDERFLOW;
      end else begin
        count_nxt = count_r - CW'(1);
        out_data_nxt[VALUE_BITS-1:0] = val[0];
        out_data_nxt[PB-1:VALUE_BITS] = pri[0];
      end
    end
    out_data_nxt[PB+CB-1:PB] = CB'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      out_data_r <= out_data_nxt;
      status_r   <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = status_r;

endmodule

>>> dv/tb.sv
// Self-checking testbench for sorted_priority_queue: random insert/remove streams with
// random idling on both sides, checked against an in-bench sorted-array predictor.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module tb;

  localparam int QDEPTH      = spq_pkg::DEPTH_DEF;
  localparam int RANDOM_CMDS = 750;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    spq_pkg::cmd_t cmd;
    logic [15:0]   value;
    logic [7:0]    prio;
  } queue_cmd_t;

  typedef struct {
    spq_pkg::status_t status;
    logic [15:0]      value;
    logic [7:0]       prio;
    logic [3:0]       count;
  } queue_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // item_value, item_priority
  logic        in_tuser;   // command
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // out_value, out_priority, entry_count, pad
  logic [1:0]  out_tuser;  // status

  queue_cmd_t    cmd_backlog[$];
  queue_result_t awaited_results[$];
  logic [15:0]   mdl_vals[QDEPTH];
  logic [7:0]    mdl_pris[QDEPTH];
  int            mdl_count;
  int            total_cmds;
  int            accepted_cmds;
  int            error_count;
  int            cycle_count;
  logic          in_accepted;
  int            in_gap;
  int            in_quiet;
  int            out_stall;
  int            out_quiet;

  sorted_priority_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  // Mostly short gaps, a few long ones, and occasional stretches with none.
  function automatic int pick_gap(inout int quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if (r < 5) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic queue_result_t predict_queue_op(queue_cmd_t c);
    queue_result_t res;
    int pos;
    res.status = spq_pkg::STATUS_DONE;
    res.value  = '0;
    res.prio   = '0;
    if (c.cmd == spq_pkg::CMD_INSERT) begin
      if (mdl_count >= QDEPTH) begin
        res.status = spq_pkg::STATUS_OVERFLOW;
      end else begin
        pos = 0;
        while (pos < mdl_count && mdl_pris[pos] >= c.prio) pos++;
        for (int i = mdl_count; i > pos; i--) begin
          mdl_vals[i] = mdl_vals[i-1];
          mdl_pris[i] = mdl_pris[i-1];
        end
        mdl_vals[pos] = c.value;
        mdl_pris[pos] = c.prio;
        mdl_count++;
      end
    end else begin
      if (mdl_count == 0) begin
        res.status = spq_pkg::STATUS_UNDERFLOW;
      end else begin
        res.value = mdl_vals[0];
        res.prio  = mdl_pris[0];
        for (int i = 1; i < mdl_count; i++) begin
          mdl_vals[i-1] = mdl_vals[i];
          mdl_pris[i-1] = mdl_pris[i];
        end
        mdl_count--;
      end
    end
    res.count = 4'(mdl_count);
    return res;
  endfunction

  task automatic push_cmd(spq_pkg::cmd_t cmd, logic [15:0] value, logic [7:0] prio);
    queue_cmd_t c;
    c.cmd   = cmd;
    c.value = value;
    c.prio  = prio;
    cmd_backlog.push_back(c);
    total_cmds++;
  endtask

  // Input driver
  always @(negedge clk) begin
    queue_cmd_t c;
    if (rst_n && (!in_tvalid || in_accepted)) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (cmd_backlog.size() != 0) begin
        c = cmd_backlog.pop_front();
        in_tuser  <= c.cmd;
        in_tdata  <= {c.prio, c.value};
        in_tvalid <= 1'b1;
        in_gap = pick_gap(in_quiet);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result-side backpressure
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall--;
    end else begin
      out_tready <= 1'b1;
      out_stall = pick_gap(out_quiet);
    end
  end

  // Monitor: predict on input transfers, check on result transfers
  always @(posedge clk) begin
    queue_cmd_t    c;
    queue_result_t exp_res;
    in_accepted <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing expected: tuser=%0d tdata=%h",
                 out_tuser, out_tdata);
          error_count++;
        end else begin
          exp_res = awaited_results.pop_front();
          if (out_tuser !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, out_tuser);
            error_count++;
          end
          if (out_tdata[15:0] !== exp_res.value) begin
            $error("out_value: expected %0d, got %0d",
                   $signed(exp_res.value), $signed(out_tdata[15:0]));
            error_count++;
          end
          if (out_tdata[23:16] !== exp_res.prio) begin
            $error("out_priority: expected %0d, got %0d", exp_res.prio, out_tdata[23:16]);
            error_count++;
          end
          if (out_tdata[27:24] !== exp_res.count) begin
            $error("entry_count: expected %0d, got %0d", exp_res.count, out_tdata[27:24]);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        c.cmd   = spq_pkg::cmd_t'(in_tuser);
        c.value = in_tdata[15:0];
        c.prio  = in_tdata[23:16];
        awaited_results.push_back(predict_queue_op(c));
        accepted_cmds++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int            n_rand;
    int            run_len;
    int            ins_pct;
    int            prio_mode;
    spq_pkg::cmd_t cmd;
    logic [7:0]    prio;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    in_accepted = 1'b0;
    in_gap = 0; in_quiet = 0; out_stall = 0; out_quiet = 0;
    mdl_count = 0; total_cmds = 0; accepted_cmds = 0;
    error_count = 0; cycle_count = 0;

    // Directed: underflow, extremes, ties in arrival order, overflow, drain past empty
    push_cmd(spq_pkg::CMD_REMOVE, 16'h1234, 8'hFF);
    push_cmd(spq_pkg::CMD_INSERT, 16'h8000, 8'd0);
    push_cmd(spq_pkg::CMD_INSERT, 16'h7FFF, 8'd255);
    push_cmd(spq_pkg::CMD_INSERT, 16'h0000, 8'd128);
    push_cmd(spq_pkg::CMD_INSERT, 16'h0001, 8'd128);
    push_cmd(spq_pkg::CMD_INSERT, 16'hFFFF, 8'd128);
    push_cmd(spq_pkg::CMD_INSERT, 16'h5555, 8'd0);
    push_cmd(spq_pkg::CMD_INSERT, 16'hAAAA, 8'd255);
    push_cmd(spq_pkg::CMD_INSERT, 16'h00FF, 8'd64);
    push_cmd(spq_pkg::CMD_INSERT, 16'h7FFF, 8'd255);
    for (int i = 0; i < 9; i++) push_cmd(spq_pkg::CMD_REMOVE, 16'hFFFF, 8'hFF);

    // Random runs leaning toward fill, toward drain or balanced, priorities often tied
    n_rand = 0;
    while (n_rand < RANDOM_CMDS) begin
      run_len   = $urandom_range(8, 40);
      ins_pct   = ($urandom_range(0, 2) == 0) ? 80 : ($urandom_range(0, 1) ? 50 : 25);
      prio_mode = $urandom_range(0, 3);
      for (int i = 0; i < run_len && n_rand < RANDOM_CMDS; i++) begin
        cmd = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::CMD_INSERT : spq_pkg::CMD_REMOVE;
        case (prio_mode)
          0: prio = 8'($urandom_range(0, 3));
          1: prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          2: prio = 8'($urandom_range(126, 130));
          default: prio = 8'($urandom);
        endcase
        push_cmd(cmd, 16'($urandom), prio);
        n_rand++;
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_cmds != total_cmds || awaited_results.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);

    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
